@@ design/wtss_pkg.sv @@
`timescale 1ns / 1ps
package wtss_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam logic [3:0] MODE_REGISTER  = 4'd0;
    localparam logic [3:0] MODE_REMOVE    = 4'd1;
    localparam logic [3:0] MODE_HEARTBEAT = 4'd2;
    localparam logic [3:0] MODE_RESOURCES = 4'd3;
    localparam logic [3:0] MODE_TASK_UP   = 4'd4;
    localparam logic [3:0] MODE_TASK_DOWN = 4'd5;
    localparam logic [3:0] MODE_DONE_UP   = 4'd6;
    localparam logic [3:0] MODE_SELECT    = 4'd7;
    localparam logic [3:0] MODE_SWEEP     = 4'd8;
    localparam logic [3:0] MODE_TICK      = 4'd9;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [20:0] SCORE_BASE    = 21'd102400;
    localparam logic [20:0] MEM_CAP       = 21'd51200;
    localparam logic [20:0] GPU_BONUS     = 21'd30720;
    localparam logic [20:0] CPLX_BONUS    = 21'd20480;
    localparam logic [6:0]  CPLX_LIMIT    = 7'd70;

    // one command as it sits in the queue
    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  slot;
        logic [1:0]  worker_kind;
        logic [7:0]  cpu_cores;
        logic [31:0] memory_mb;
        logic        has_gpu;
        logic [6:0]  cpu_usage_pct;
        logic        requires_gpu;
        logic [6:0]  complexity_tenths;
        logic [15:0] timeout_seconds;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_slot;
        logic [19:0] best_score;
        logic [4:0]  live_count;
    } rsp_t;

    // score of one entry, signed running sum clamped at zero
    function automatic logic [19:0] score_f(
        input logic [6:0]  usage,
        input logic [7:0]  running,
        input logic [31:0] memory,
        input logic [7:0]  cores,
        input logic        gpu,
        input logic [1:0]  kind,
        input logic        need_gpu,
        input logic [6:0]  cplx
    );
        logic signed [22:0] s;
        logic [20:0]        mem_c;
        mem_c = (memory < 32'd51200) ? memory[20:0] : MEM_CAP;
        // running * 10240 as running * 8192 + running * 2048
        s = $signed({2'b00, SCORE_BASE})
            - $signed({7'd0, usage, 9'd0})
            - $signed({2'b00, running, 13'd0}) - $signed({4'd0, running, 11'd0})
            + $signed({2'b00, mem_c})
            + $signed({4'd0, cores, 11'd0});
        if (need_gpu && gpu)
            s = s + $signed({2'b00, GPU_BONUS});
        if (need_gpu && !gpu)
            s = '0;
        if (cplx > CPLX_LIMIT && kind[1])
            s = s + $signed({2'b00, CPLX_BONUS});
        return s[22] ? 20'd0 : s[19:0];
    endfunction

endpackage

@@ design/wtss_front.sv @@
`timescale 1ns / 1ps
module wtss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wtss_pkg::cmd_t     in_cmd,
    output logic               q_valid,
    input  logic               q_ready,
    output wtss_pkg::cmd_t     q_cmd
);
    // two-entry queue decoupling the port from the executor
    wtss_pkg::cmd_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ design/wtss_back.sv @@
`timescale 1ns / 1ps
module wtss_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  wtss_pkg::cmd_t     q_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output wtss_pkg::rsp_t     out_rsp
);
    localparam int TABLE_ENTRIES = wtss_pkg::TABLE_ENTRIES;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  state_reg;
    wtss_pkg::cmd_t cmd_reg;
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [19:0]   top_reg;
    logic [IW-1:0] best_reg;
    logic [31:0]   now_reg;
    wtss_pkg::rsp_t rsp_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [1:0]  kind_reg   [TABLE_ENTRIES];
    logic [7:0]  cores_reg  [TABLE_ENTRIES];
    logic [31:0] memory_reg [TABLE_ENTRIES];
    logic        gpu_reg    [TABLE_ENTRIES];
    logic [6:0]  usage_reg  [TABLE_ENTRIES];
    logic [7:0]  run_reg    [TABLE_ENTRIES];
    logic [31:0] done_reg   [TABLE_ENTRIES];
    logic [31:0] seen_reg   [TABLE_ENTRIES];

    // slot lookup for direct commands
    logic          hit;
    logic [IW-1:0] s;
    logic          has_free;
    logic [IW-1:0] free_idx;
    logic [19:0]   cur_score;

    always_comb
    begin
        s   = cmd_reg.slot[IW-1:0];
        hit = ({28'd0, cmd_reg.slot} < 32'(TABLE_ENTRIES)) && valid_reg[s];
        has_free = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // shared scoring unit, one entry per cycle
    assign cur_score = wtss_pkg::score_f(usage_reg[idx_reg], run_reg[idx_reg],
        memory_reg[idx_reg], cores_reg[idx_reg], gpu_reg[idx_reg], kind_reg[idx_reg],
        cmd_reg.requires_gpu, cmd_reg.complexity_tenths);

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_rsp   = rsp_reg;

    // valid bits after this cycle of the command
    always_comb
    begin
        valid_next = valid_reg;
        if (state_reg == ST_SCAN)
        begin
            if (cmd_reg.mode == wtss_pkg::MODE_REGISTER && has_free)
                valid_next[free_idx] = 1'b1;
            if (cmd_reg.mode == wtss_pkg::MODE_REMOVE && hit)
                valid_next[s] = 1'b0;
            if (cmd_reg.mode == wtss_pkg::MODE_SWEEP && valid_reg[idx_reg]
                && (now_reg - seen_reg[idx_reg]) > {16'd0, cmd_reg.timeout_seconds})
                valid_next[idx_reg] = 1'b0;
        end
    end

    // live count of the table after this command
    logic [CW-1:0] live_next;
    always_comb
    begin
        live_next = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            live_next = live_next + CW'(valid_next[i]);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
            cmd_reg <= q_cmd;
        if (state_reg == ST_SCAN)
        begin
            rsp_reg.live_count <= 5'(live_next);
            unique case (cmd_reg.mode)
                wtss_pkg::MODE_REGISTER:
                begin
                    rsp_reg.status <= wtss_pkg::STATUS_FULL;
                    rsp_reg.chosen_slot <= '0;
                    if (has_free)
                    begin
                        kind_reg[free_idx]   <= cmd_reg.worker_kind;
                        cores_reg[free_idx]  <= cmd_reg.cpu_cores;
                        memory_reg[free_idx] <= cmd_reg.memory_mb;
                        gpu_reg[free_idx]    <= cmd_reg.has_gpu;
                        usage_reg[free_idx]  <= '0;
                        run_reg[free_idx]    <= '0;
                        done_reg[free_idx]   <= '0;
                        seen_reg[free_idx]   <= now_reg;
                        rsp_reg.status <= wtss_pkg::STATUS_DONE;
                        rsp_reg.chosen_slot <= 4'(free_idx);
                    end
                    rsp_reg.best_score <= '0;
                end
                wtss_pkg::MODE_REMOVE, wtss_pkg::MODE_HEARTBEAT,
                wtss_pkg::MODE_RESOURCES, wtss_pkg::MODE_TASK_UP,
                wtss_pkg::MODE_TASK_DOWN, wtss_pkg::MODE_DONE_UP:
                begin
                    rsp_reg.status <= hit ? wtss_pkg::STATUS_DONE
                                          : wtss_pkg::STATUS_MISSING;
                    rsp_reg.chosen_slot <= '0;
                    rsp_reg.best_score  <= '0;
                    if (hit)
                    begin
                        if (cmd_reg.mode == wtss_pkg::MODE_HEARTBEAT)
                            seen_reg[s] <= now_reg;
                        if (cmd_reg.mode == wtss_pkg::MODE_RESOURCES)
                        begin
                            usage_reg[s]  <= cmd_reg.cpu_usage_pct;
                            memory_reg[s] <= cmd_reg.memory_mb;
                        end
                        if (cmd_reg.mode == wtss_pkg::MODE_TASK_UP && run_reg[s] != 8'hFF)
                            run_reg[s] <= run_reg[s] + 8'd1;
                        if (cmd_reg.mode == wtss_pkg::MODE_TASK_DOWN && run_reg[s] != 8'h0)
                            run_reg[s] <= run_reg[s] - 8'd1;
                        if (cmd_reg.mode == wtss_pkg::MODE_DONE_UP && ~&done_reg[s])
                            done_reg[s] <= done_reg[s] + 32'd1;
                    end
                end
                wtss_pkg::MODE_SELECT:
                begin
                    if (idx_reg == IW'(TABLE_ENTRIES - 1))
                    begin
                        // final entry folded in here
                        if (valid_reg[idx_reg] && (!found_reg || cur_score > top_reg))
                        begin
                            rsp_reg.status      <= wtss_pkg::STATUS_DONE;
                            rsp_reg.chosen_slot <= 4'(idx_reg);
                            rsp_reg.best_score  <= cur_score;
                        end
                        else
                        begin
                            rsp_reg.status      <= found_reg ? wtss_pkg::STATUS_DONE
                                                             : wtss_pkg::STATUS_MISSING;
                            rsp_reg.chosen_slot <= found_reg ? 4'(best_reg) : 4'd0;
                            rsp_reg.best_score  <= found_reg ? top_reg : 20'd0;
                        end
                    end
                end
                default:
                begin
                    rsp_reg.status      <= wtss_pkg::STATUS_DONE;
                    rsp_reg.chosen_slot <= '0;
                    rsp_reg.best_score  <= '0;
                end
            endcase
        end
    end

    logic last;
    logic scan_mode;
    assign last = (idx_reg == IW'(TABLE_ENTRIES - 1));
    assign scan_mode = (cmd_reg.mode == wtss_pkg::MODE_SELECT)
                    || (cmd_reg.mode == wtss_pkg::MODE_SWEEP);

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            now_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            top_reg   <= '0;
            best_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (q_valid)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cmd_reg.mode == wtss_pkg::MODE_TICK)
                        now_reg <= now_reg + 32'd1;
                    if (cmd_reg.mode == wtss_pkg::MODE_SELECT && valid_reg[idx_reg]
                        && (!found_reg || cur_score > top_reg))
                    begin
                        found_reg <= 1'b1;
                        top_reg   <= cur_score;
                        best_reg  <= idx_reg;
                    end
                    if (!scan_mode || last)
                        state_reg <= ST_OUT;
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ design/worker_table_score_selector.sv @@
`timescale 1ns / 1ps
// worker table with score-based selection
// s_axis carries one command per request; m_axis returns one result per request
// s_axis_tdata fields, lowest bit up: mode, slot, worker_kind, cpu_cores,
//   memory_mb, has_gpu, cpu_usage_pct, requires_gpu, complexity_tenths,
//   timeout_seconds (82 bits, padded to 88)
// m_axis_tdata fields, lowest bit up: status, chosen_slot, best_score,
//   live_count (31 bits, padded to 32)
// a two-entry command queue sits in front of the executor
// select and sweep walk the 16 entries one a cycle, select scoring them
//   through one scoring unit; the executor takes one request at a time, so
//   a new request starts only after the last result is accepted
// reset empties the table and clears the seconds counter
// a stalled m_axis holds the result; the queue keeps taking up to two requests
module worker_table_score_selector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // mode, slot, kind, cores, mem, gpu, usage, rgpu, cplx, tmo
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // status, chosen_slot, best_score, live_count
);
    wtss_pkg::cmd_t in_cmd, q_cmd;
    wtss_pkg::rsp_t rsp;
    logic q_valid, q_ready;

    assign in_cmd.mode              = s_axis_tdata[3:0];
    assign in_cmd.slot              = s_axis_tdata[7:4];
    assign in_cmd.worker_kind       = s_axis_tdata[9:8];
    assign in_cmd.cpu_cores         = s_axis_tdata[17:10];
    assign in_cmd.memory_mb         = s_axis_tdata[49:18];
    assign in_cmd.has_gpu           = s_axis_tdata[50];
    assign in_cmd.cpu_usage_pct     = s_axis_tdata[57:51];
    assign in_cmd.requires_gpu      = s_axis_tdata[58];
    assign in_cmd.complexity_tenths = s_axis_tdata[65:59];
    assign in_cmd.timeout_seconds   = s_axis_tdata[81:66];

    // padding bits carry nothing
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[87:82];

    wtss_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    wtss_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
    );

    assign m_axis_tdata = {1'b0, rsp.live_count, rsp.best_score, rsp.chosen_slot, rsp.status};
endmodule

@@ design/wtss_checker.sv @@
`timescale 1ns / 1ps
module wtss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // a result waiting stays offered
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    // a result waiting holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // status code never reserved value
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status");

    // non-done results carry no slot and no score
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != wtss_pkg::STATUS_DONE
        |-> m_axis_tdata[25:2] == 24'd0)
        else $error("score on failed request");

    // live count never above table size
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:26] <= 5'(wtss_pkg::TABLE_ENTRIES))
        else $error("live count too large");
endmodule

bind worker_table_score_selector wtss_checker u_wtss_checker (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

@@ test/worker_table_score_selector_tb.sv @@
`timescale 1ns / 1ps
module worker_table_score_selector_tb;

    localparam int ENTRIES     = wtss_pkg::TABLE_ENTRIES;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [3:0]  mode;
        logic [3:0]  slot;
        logic [1:0]  worker_kind;
        logic [7:0]  cpu_cores;
        logic [31:0] memory_mb;
        logic        has_gpu;
        logic [6:0]  cpu_usage_pct;
        logic        requires_gpu;
        logic [6:0]  complexity_tenths;
        logic [15:0] timeout_seconds;
    } command_t;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  chosen_slot;
        logic [19:0] best_score;
        logic [4:0]  live_count;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // mode, slot, kind, cores, mem, gpu, usage, rgpu, cplx, tmo
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // status, chosen_slot, best_score, live_count

    // shadow table
    logic        tbl_valid [ENTRIES];
    logic [1:0]  tbl_kind [ENTRIES];
    logic [7:0]  tbl_cores [ENTRIES];
    logic [31:0] tbl_memory [ENTRIES];
    logic        tbl_gpu [ENTRIES];
    logic [6:0]  tbl_usage [ENTRIES];
    logic [7:0]  tbl_running [ENTRIES];
    logic [31:0] tbl_completed [ENTRIES];
    logic [31:0] tbl_last_seen [ENTRIES];
    logic [31:0] now_seconds;

    answer_t pending_answers[$];
    int      error_count;
    int      cycle_count;

    worker_table_score_selector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // score of one shadow entry in 1/1024 units
    function automatic longint entry_score(int i, logic need_gpu, logic [6:0] cplx);
        longint s;
        s = 102400;
        s -= longint'(tbl_usage[i]) * 512;
        s -= longint'(tbl_running[i]) * 10240;
        s += (tbl_memory[i] < 32'd51200) ? longint'(tbl_memory[i]) : 51200;
        s += longint'(tbl_cores[i]) * 2048;
        if (need_gpu && tbl_gpu[i])
            s += 30720;
        if (need_gpu && !tbl_gpu[i])
            s = 0;
        if (cplx > 7'd70 && tbl_kind[i][1])
            s += 20480;
        return (s < 0) ? 0 : s;
    endfunction

    // apply one command to the shadow table and give its answer
    function automatic answer_t apply_command(command_t c);
        answer_t a;
        int      s;
        logic    hit;
        longint  top;
        longint  v;
        int      n;
        a.status = wtss_pkg::STATUS_DONE;
        a.chosen_slot = '0;
        a.best_score = '0;
        s = int'(c.slot);
        hit = tbl_valid[s];
        if (c.mode >= wtss_pkg::MODE_REMOVE && c.mode <= wtss_pkg::MODE_DONE_UP && !hit)
            a.status = wtss_pkg::STATUS_MISSING;
        else
        begin
            case (c.mode)
                wtss_pkg::MODE_REGISTER:
                begin
                    a.status = wtss_pkg::STATUS_FULL;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!tbl_valid[i] && a.status == wtss_pkg::STATUS_FULL)
                        begin
                            tbl_valid[i] = 1'b1;
                            tbl_kind[i] = c.worker_kind;
                            tbl_cores[i] = c.cpu_cores;
                            tbl_memory[i] = c.memory_mb;
                            tbl_gpu[i] = c.has_gpu;
                            tbl_usage[i] = '0;
                            tbl_running[i] = '0;
                            tbl_completed[i] = '0;
                            tbl_last_seen[i] = now_seconds;
                            a.status = wtss_pkg::STATUS_DONE;
                            a.chosen_slot = i[3:0];
                        end
                    end
                end
                wtss_pkg::MODE_REMOVE:    tbl_valid[s] = 1'b0;
                wtss_pkg::MODE_HEARTBEAT: tbl_last_seen[s] = now_seconds;
                wtss_pkg::MODE_RESOURCES:
                begin
                    tbl_usage[s] = c.cpu_usage_pct;
                    tbl_memory[s] = c.memory_mb;
                end
                wtss_pkg::MODE_TASK_UP:   if (tbl_running[s] != 8'hFF) tbl_running[s]++;
                wtss_pkg::MODE_TASK_DOWN: if (tbl_running[s] != 8'h00) tbl_running[s]--;
                wtss_pkg::MODE_DONE_UP:   if (tbl_completed[s] != '1) tbl_completed[s]++;
                wtss_pkg::MODE_SELECT:
                begin
                    top = -1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (tbl_valid[i])
                        begin
                            v = entry_score(i, c.requires_gpu, c.complexity_tenths);
                            if (v > top)
                            begin
                                top = v;
                                a.chosen_slot = i[3:0];
                            end
                        end
                    end
                    if (top < 0)
                    begin
                        a.status = wtss_pkg::STATUS_MISSING;
                        a.chosen_slot = '0;
                    end
                    else
                        a.best_score = top[19:0];
                end
                wtss_pkg::MODE_SWEEP:
                    for (int i = 0; i < ENTRIES; i++)
                        if (tbl_valid[i] &&
                            (now_seconds - tbl_last_seen[i]) > {16'd0, c.timeout_seconds})
                            tbl_valid[i] = 1'b0;
                wtss_pkg::MODE_TICK:      now_seconds = now_seconds + 32'd1;
                default:        ;
            endcase
        end
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            n += int'(tbl_valid[i]);
        a.live_count = n[4:0];
        return a;
    endfunction

    // no gap half the time, otherwise mostly short gaps and a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic command_t random_command(logic [3:0] mode);
        command_t c;
        c.mode = mode;
        c.slot = 4'($urandom_range(0, 15));
        c.worker_kind = 2'($urandom_range(0, 3));
        c.cpu_cores = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 64));
        case ($urandom_range(0, 3))
            0:       c.memory_mb = $urandom_range(0, 60000);
            1:       c.memory_mb = $urandom();
            2:       c.memory_mb = 32'hFFFF_FFFF;
            default: c.memory_mb = $urandom_range(40000, 52000);
        endcase
        c.has_gpu = 1'($urandom_range(0, 1));
        c.cpu_usage_pct = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(101, 127))
                                                        : 7'($urandom_range(0, 100));
        c.requires_gpu = 1'($urandom_range(0, 1));
        c.complexity_tenths = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
                                                            : 7'($urandom_range(60, 100));
        c.timeout_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                         : 16'($urandom_range(0, 6));
        return c;
    endfunction

    // send one request and record its expected answer
    task automatic send_command(command_t c);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {6'd0, c.timeout_seconds, c.complexity_tenths, c.requires_gpu,
                         c.cpu_usage_pct, c.has_gpu, c.memory_mb, c.cpu_cores,
                         c.worker_kind, c.slot, c.mode};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_answers = {pending_answers, apply_command(c)};
    endtask

    // result side backpressure
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            @(posedge clk);
            g = gap_length();
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // compare each result against the oldest expectation
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (m_axis_tdata[1:0] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[5:2] !== e.chosen_slot)
                begin
                    $error("chosen_slot expected %0d actual %0d", e.chosen_slot,
                           m_axis_tdata[5:2]);
                    error_count++;
                end
                if (m_axis_tdata[25:6] !== e.best_score)
                begin
                    $error("best_score expected %0d actual %0d", e.best_score,
                           m_axis_tdata[25:6]);
                    error_count++;
                end
                if (m_axis_tdata[30:26] !== e.live_count)
                begin
                    $error("live_count expected %0d actual %0d", e.live_count,
                           m_axis_tdata[30:26]);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // directed: fill, overflow, edge fields, every mode but task up, empty select
    task automatic test_directed();
        command_t c;
        c = random_command(wtss_pkg::MODE_SELECT);
        send_command(c);
        c.mode = wtss_pkg::MODE_REMOVE;
        send_command(c);
        c.mode = wtss_pkg::MODE_SWEEP;
        send_command(c);
        for (int i = 0; i < ENTRIES + 1; i++)
        begin
            c = random_command(wtss_pkg::MODE_REGISTER);
            c.worker_kind = i[1:0];
            c.cpu_cores = (i == 0) ? 8'h00 : 8'hFF;
            c.memory_mb = (i == 1) ? 32'h0 : 32'hFFFF_FFFF;
            send_command(c);
        end
        c = random_command(wtss_pkg::MODE_RESOURCES);
        c.slot = 4'd15;
        c.cpu_usage_pct = 7'h7F;
        c.memory_mb = 32'd0;
        send_command(c);
        c.mode = wtss_pkg::MODE_TASK_DOWN;
        send_command(c);
        c.mode = wtss_pkg::MODE_DONE_UP;
        send_command(c);
        c.mode = wtss_pkg::MODE_HEARTBEAT;
        send_command(c);
        c = random_command(wtss_pkg::MODE_SELECT);
        c.requires_gpu = 1'b1;
        c.complexity_tenths = 7'h7F;
        send_command(c);
        c.mode = 4'd15;
        send_command(c);
        c.mode = wtss_pkg::MODE_TICK;
        send_command(c);
        c.mode = wtss_pkg::MODE_SWEEP;
        c.timeout_seconds = 16'hFFFF;
        send_command(c);
        c.timeout_seconds = 16'd0;
        send_command(c);
    endtask

    // running count saturation at 255
    task automatic test_running_saturation();
        command_t c;
        c = random_command(wtss_pkg::MODE_REGISTER);
        send_command(c);
        c.mode = wtss_pkg::MODE_TASK_UP;
        c.slot = 4'd0;
        repeat (258) send_command(c);
        c.mode = wtss_pkg::MODE_SELECT;
        send_command(c);
    endtask

    // random command mix with lifecycle-weighted modes
    task automatic test_random_mix();
        command_t c;
        int       r;
        logic [3:0] m;
        for (int k = 0; k < 1500; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 16)      m = wtss_pkg::MODE_REGISTER;
            else if (r < 22) m = wtss_pkg::MODE_REMOVE;
            else if (r < 30) m = wtss_pkg::MODE_HEARTBEAT;
            else if (r < 40) m = wtss_pkg::MODE_RESOURCES;
            else if (r < 50) m = wtss_pkg::MODE_TASK_UP;
            else if (r < 56) m = wtss_pkg::MODE_TASK_DOWN;
            else if (r < 61) m = wtss_pkg::MODE_DONE_UP;
            else if (r < 78) m = wtss_pkg::MODE_SELECT;
            else if (r < 84) m = wtss_pkg::MODE_SWEEP;
            else if (r < 97) m = wtss_pkg::MODE_TICK;
            else             m = 4'($urandom_range(10, 15));
            c = random_command(m);
            send_command(c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        error_count = 0;
        cycle_count = 0;
        now_seconds = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_kind[i] = '0;
            tbl_cores[i] = '0;
            tbl_memory[i] = '0;
            tbl_gpu[i] = 1'b0;
            tbl_usage[i] = '0;
            tbl_running[i] = '0;
            tbl_completed[i] = '0;
            tbl_last_seen[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_running_saturation();
        test_random_mix();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ worker_table_score_selector.f @@
design/wtss_pkg.sv
design/wtss_front.sv
design/wtss_back.sv
design/worker_table_score_selector.sv
design/wtss_checker.sv
test/worker_table_score_selector_tb.sv
